// ----- src/drfs_pkg.sv -----
// drfs_pkg: shared constants for the dual record frame synchronizer
// no dependencies; imported by the interfaces, the top level and the checker
package drfs_pkg;

    localparam int FRAME_BYTES_DEF = 11;

    localparam int BYTE_W = 8;
    localparam int CFG_W  = 8;

    localparam logic [BYTE_W-1:0] HDR_A   = 8'h21;
    localparam logic [BYTE_W-1:0] HDR_B   = 8'h22;
    localparam logic [BYTE_W-1:0] HDR_LEN = 8'h08;
    localparam logic [BYTE_W-1:0] CHK_INV = 8'hFF;
    localparam logic [BYTE_W-1:0] IDLE_MAX = 8'hFF;

    localparam logic [CFG_W-1:0] TIMEOUT_RST = 8'd20;

    // operation codes of an input transaction
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef logic [1:0] marks_t;

    localparam marks_t MARK_A    = 2'b01;
    localparam marks_t MARK_B    = 2'b10;
    localparam marks_t MARK_BOTH = 2'b11;
    localparam marks_t MARK_NONE = 2'b00;

endpackage

// ----- src/drfs_if.sv -----
// drfs_in_if / drfs_out_if: valid-ready channels of the frame synchronizer
// depends on drfs_pkg for field widths
interface drfs_in_if;
    logic                        valid;
    logic                        ready;
    logic                        operation;
    logic [drfs_pkg::BYTE_W-1:0] in_byte;

    modport source (output valid, output operation, output in_byte, input ready);
    modport sink   (input valid, input operation, input in_byte, output ready);
endinterface

interface drfs_out_if;
    logic                        valid;
    logic                        ready;
    logic [drfs_pkg::BYTE_W-1:0] out_byte;
    logic                        out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

// ----- src/drfs_report_buf.sv -----
// drfs_report_buf: snapshot of the combined report, shifted out one byte per transaction
// depends on drfs_pkg and drfs_out_if
module drfs_report_buf #(
    parameter int NUM_BYTES = 2 * drfs_pkg::FRAME_BYTES_DEF
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      load,
    input  logic [NUM_BYTES-1:0][drfs_pkg::BYTE_W-1:0] load_data,
    output logic                                      busy,
    drfs_out_if.source                                out_ch
);
    import drfs_pkg::*;

    localparam int CNT_W = $clog2(NUM_BYTES + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(NUM_BYTES);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    logic [NUM_BYTES-1:0][BYTE_W-1:0] shift_reg, shift_next;
    logic [CNT_W-1:0]                 cnt_reg, cnt_next;
    logic                             take;

    assign take            = out_ch.valid && out_ch.ready;
    assign out_ch.valid    = cnt_reg != '0;
    assign out_ch.out_byte = shift_reg[0];
    assign out_ch.out_last = cnt_reg == CNT_ONE;
    assign busy            = cnt_reg != '0;

    always_comb
    begin
        shift_next = shift_reg;
        cnt_next   = cnt_reg;
        if (load)
        begin
            shift_next = load_data;
            cnt_next   = CNT_FULL;
        end
        else if (take)
        begin
            shift_next = {{BYTE_W{1'b0}}, shift_reg[NUM_BYTES-1:1]};
            cnt_next   = cnt_reg - CNT_ONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
    end

endmodule

// ----- src/dual_record_frame_sync_top.sv -----
// dual_record_frame_sync_top: byte-stream frame synchronizer with two stored records
// depends on drfs_pkg, drfs_if and drfs_report_buf
//
// in_ch carries one transaction per cycle while in_ch.ready is high: operation 0 is a received byte,
// operation 1 a one-second tick. Bytes fill a sliding window of FRAME_BYTES;
// a full window with header 0x21/0x22, length 0x08 and a good inverted-sum
// checksum is taken as a frame and stored in its record, otherwise the oldest
// byte drops out. A running sum of the window keeps the checksum to one add.
// When both records have been seen and one changed, the report (record 0x21,
// then 0x22, 2*FRAME_BYTES bytes, out_last on the final byte) is copied into
// an output shift register and drained on out_ch, one byte per transaction.
// Each input transaction is absorbed when it is accepted; the first report byte is
// valid the cycle after the completing byte is accepted. in_ch.ready drops
// only while a report is still draining and the window is one byte short of
// a frame, so a stalled out_ch holds back input at most at that point.
// cfg_wr_en writes timeout_reg (reset 20). Reset empties window and marks,
// clears the records and leaves out_ch idle.
module dual_record_frame_sync_top #(
    parameter int FRAME_BYTES = drfs_pkg::FRAME_BYTES_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [drfs_pkg::CFG_W-1:0] cfg_wr_data,
    drfs_in_if.sink                    in_ch,
    drfs_out_if.source                 out_ch
);
    import drfs_pkg::*;

    localparam int WIN_DEPTH = FRAME_BYTES - 1;
    localparam int IDX_W     = $clog2(WIN_DEPTH);
    localparam int FILL_W    = $clog2(FRAME_BYTES);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WIN_DEPTH);
    localparam logic [FILL_W-1:0] FILL_ONE  = FILL_W'(1);

    logic [CFG_W-1:0]  timeout_reg;
    logic [BYTE_W-1:0] win_reg   [WIN_DEPTH];
    logic [BYTE_W-1:0] win_next  [WIN_DEPTH];
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [BYTE_W-1:0] sum_reg, sum_next;
    logic [BYTE_W-1:0] rec_a_reg [FRAME_BYTES];
    logic [BYTE_W-1:0] rec_a_next[FRAME_BYTES];
    logic [BYTE_W-1:0] rec_b_reg [FRAME_BYTES];
    logic [BYTE_W-1:0] rec_b_next[FRAME_BYTES];
    marks_t            seen_reg, seen_next;
    marks_t            changed_reg, changed_next;
    logic [BYTE_W-1:0] idle_reg, idle_next;

    logic [BYTE_W-1:0] full_win[FRAME_BYTES];
    logic              accept;
    logic              at_full;
    logic              frame_ok;
    logic              slot_b;
    logic              differs;
    marks_t            slot_mask;
    marks_t            seen_new;
    marks_t            changed_new;
    logic              report;
    logic [BYTE_W-1:0] idle_inc;
    logic              rb_busy;
    logic [2*FRAME_BYTES-1:0][BYTE_W-1:0] report_data;

    assign accept      = in_ch.valid && in_ch.ready;
    assign at_full     = fill_reg == FILL_FULL;
    assign in_ch.ready = !(rb_busy && at_full);

    always_comb
    begin
        for (int i = 0; i < WIN_DEPTH; i++)
        begin
            full_win[i] = win_reg[i];
        end
        full_win[WIN_DEPTH] = in_ch.in_byte;
    end

    // frame test on the window completed by the incoming byte
    assign frame_ok = at_full && (win_reg[0] == HDR_A || win_reg[0] == HDR_B)
                      && win_reg[1] == HDR_LEN
                      && ((sum_reg ^ CHK_INV) == in_ch.in_byte);
    assign slot_b    = win_reg[0] != HDR_A;
    assign slot_mask = slot_b ? MARK_B : MARK_A;

    always_comb
    begin
        differs = 1'b0;
        for (int i = 0; i < FRAME_BYTES; i++)
        begin
            if (full_win[i] != (slot_b ? rec_b_reg[i] : rec_a_reg[i]))
            begin
                differs = 1'b1;
            end
        end
    end

    assign seen_new    = seen_reg | slot_mask;
    assign changed_new = differs ? (changed_reg | slot_mask) : changed_reg;
    assign report      = accept && in_ch.operation == OP_BYTE && frame_ok
                         && seen_new == MARK_BOTH && changed_new != MARK_NONE;
    assign idle_inc    = (idle_reg == IDLE_MAX) ? idle_reg : idle_reg + 8'd1;

    always_comb
    begin
        win_next     = win_reg;
        fill_next    = fill_reg;
        sum_next     = sum_reg;
        rec_a_next   = rec_a_reg;
        rec_b_next   = rec_b_reg;
        seen_next    = seen_reg;
        changed_next = changed_reg;
        idle_next    = idle_reg;
        if (accept)
        begin
            if (in_ch.operation == OP_TICK)
            begin
                idle_next = idle_inc;
                if (idle_inc > timeout_reg)
                begin
                    fill_next = '0;
                    sum_next  = '0;
                end
            end
            else
            begin
                idle_next = '0;
                if (!at_full)
                begin
                    win_next[fill_reg[IDX_W-1:0]] = in_ch.in_byte;
                    fill_next = fill_reg + FILL_ONE;
                    sum_next  = sum_reg + in_ch.in_byte;
                end
                else if (frame_ok)
                begin
                    fill_next = '0;
                    sum_next  = '0;
                    if (slot_b)
                    begin
                        rec_b_next = full_win;
                    end
                    else
                    begin
                        rec_a_next = full_win;
                    end
                    seen_next    = seen_new;
                    changed_next = changed_new;
                    if (seen_new == MARK_BOTH && changed_new != MARK_NONE)
                    begin
                        seen_next    = MARK_NONE;
                        changed_next = MARK_NONE;
                    end
                end
                else
                begin
                    // resync: drop the oldest byte
                    for (int i = 0; i < WIN_DEPTH; i++)
                    begin
                        win_next[i] = full_win[i+1];
                    end
                    sum_next = sum_reg + in_ch.in_byte - win_reg[0];
                end
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < FRAME_BYTES; i++)
        begin
            report_data[i]               = rec_a_next[i];
            report_data[FRAME_BYTES + i] = rec_b_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RST;
            fill_reg    <= '0;
            sum_reg     <= '0;
            seen_reg    <= MARK_NONE;
            changed_reg <= MARK_NONE;
            idle_reg    <= '0;
            for (int i = 0; i < FRAME_BYTES; i++)
            begin
                rec_a_reg[i] <= '0;
                rec_b_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_wr_en)
            begin
                timeout_reg <= cfg_wr_data;
            end
            fill_reg    <= fill_next;
            sum_reg     <= sum_next;
            seen_reg    <= seen_next;
            changed_reg <= changed_next;
            idle_reg    <= idle_next;
            rec_a_reg   <= rec_a_next;
            rec_b_reg   <= rec_b_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
    end

    drfs_report_buf #(
        .NUM_BYTES (2 * FRAME_BYTES)
    ) u_report_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (report),
        .load_data (report_data),
        .busy      (rb_busy),
        .out_ch    (out_ch)
    );

endmodule

// ----- src/drfs_checker.sv -----
// drfs_checker: port-level assertions for dual_record_frame_sync_top
// depends on drfs_pkg; bound to the top level at the end of this file
module drfs_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        in_operation,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [drfs_pkg::BYTE_W-1:0] out_byte,
    input logic                        out_last
);
    import drfs_pkg::*;

    // a stalled report byte holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
        else $error("report byte changed under stall");

    // reports never run into each other
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && out_last |=> !out_valid)
        else $error("report followed without a gap");

    // input is only held back while a report drains
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with the output idle");

    // a tick never starts a report
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_operation == OP_TICK && !out_valid |=> !out_valid)
        else $error("tick started a report");

endmodule

bind dual_record_frame_sync_top drfs_checker u_drfs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .in_operation (in_ch.operation),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_byte     (out_ch.out_byte),
    .out_last     (out_ch.out_last)
);

// ----- test/testbench.sv -----
// testbench for dual_record_frame_sync_top: directed and random byte/tick streams
// depends on drfs_pkg, drfs_if and the top level; reports are predicted in the bench
`timescale 1ns / 1ps

module testbench;
    import drfs_pkg::*;

    localparam int FRAME        = FRAME_BYTES_DEF;
    localparam int IDLE_PCT     = 13;
    localparam int HOLD_CYCLES  = 200;
    localparam int STALL_LIMIT  = 2000;
    localparam int SETTLE       = 6;
    localparam int PHASE_ITEMS  = 20;
    localparam int LONG_TICKS   = 30;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } report_byte_t;

    typedef enum {PAY_RANDOM, PAY_REPEAT, PAY_ZERO, PAY_ONES} payload_t;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [CFG_W-1:0] cfg_wr_data;

    drfs_in_if  in_ch ();
    drfs_out_if out_ch ();

    dual_record_frame_sync_top #(.FRAME_BYTES(FRAME)) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_ch       (in_ch),
        .out_ch      (out_ch)
    );

    // predicted synchronizer state
    logic [BYTE_W-1:0] win_bytes [FRAME];
    int                win_fill;
    logic [BYTE_W-1:0] rec_bytes [2*FRAME];
    marks_t            seen_mask;
    marks_t            changed_mask;
    logic [BYTE_W-1:0] idle_secs;
    logic [CFG_W-1:0]  timeout_secs;

    report_byte_t      pending_report [$];
    logic [BYTE_W-1:0] last_frame [2][FRAME];

    int unsigned items_sent;
    int unsigned ticks_sent;
    int unsigned frames_sent;
    int unsigned reports_due;
    int unsigned bytes_checked;
    int unsigned errors;
    int unsigned stall_cycles;
    int unsigned hold_trigger;
    bit          steady;

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic void predict_report(input logic op, input logic [BYTE_W-1:0] value);
        logic [BYTE_W-1:0] sum;
        int                slot;
        bit                differs;
        if (op == OP_TICK)
        begin
            if (idle_secs != IDLE_MAX)
                idle_secs++;
            if (idle_secs > timeout_secs)
                win_fill = 0;
            return;
        end
        idle_secs = '0;
        win_bytes[win_fill] = value;
        win_fill++;
        if (win_fill != FRAME)
            return;
        sum = '0;
        for (int i = 0; i < FRAME - 1; i++)
            sum += win_bytes[i];
        if ((win_bytes[0] == HDR_A || win_bytes[0] == HDR_B) && win_bytes[1] == HDR_LEN
            && (sum ^ CHK_INV) == win_bytes[FRAME-1])
        begin
            slot    = (win_bytes[0] == HDR_A) ? 0 : 1;
            differs = 1'b0;
            for (int i = 0; i < FRAME; i++)
            begin
                if (rec_bytes[slot*FRAME+i] != win_bytes[i])
                    differs = 1'b1;
                rec_bytes[slot*FRAME+i] = win_bytes[i];
            end
            if (differs)
                changed_mask |= (slot == 0) ? MARK_A : MARK_B;
            seen_mask |= (slot == 0) ? MARK_A : MARK_B;
            if (seen_mask == MARK_BOTH && changed_mask != MARK_NONE)
            begin
                for (int i = 0; i < 2*FRAME; i++)
                    pending_report.push_back('{data: rec_bytes[i], last: (i == 2*FRAME-1)});
                seen_mask    = MARK_NONE;
                changed_mask = MARK_NONE;
                reports_due++;
            end
            win_fill = 0;
        end
        else
        begin
            // drop the oldest byte and keep looking
            for (int i = 0; i < FRAME - 1; i++)
                win_bytes[i] = win_bytes[i+1];
            win_fill = FRAME - 1;
        end
    endfunction

    task automatic send_item(input logic op, input logic [BYTE_W-1:0] value);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.operation <= op;
        in_ch.in_byte   <= value;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        predict_report(op, value);
        items_sent++;
        if (op == OP_TICK)
            ticks_sent++;
    endtask

    // builds one frame with a good checksum, optionally breaks one bit,
    // and slips n_ticks ticks in after the first half
    task automatic send_frame(input logic [BYTE_W-1:0] hdr, input payload_t kind,
                              input bit corrupt, input int n_ticks);
        logic [BYTE_W-1:0] fr [FRAME];
        logic [BYTE_W-1:0] sum;
        int                slot;
        int                pos;
        slot  = (hdr == HDR_A) ? 0 : 1;
        fr[0] = hdr;
        fr[1] = HDR_LEN;
        for (int i = 2; i < FRAME - 1; i++)
        begin
            case (kind)
                PAY_ZERO:   fr[i] = 8'h00;
                PAY_ONES:   fr[i] = 8'hFF;
                PAY_REPEAT: fr[i] = last_frame[slot][i];
                default:    fr[i] = 8'($urandom);
            endcase
        end
        sum = '0;
        for (int i = 0; i < FRAME - 1; i++)
            sum += fr[i];
        fr[FRAME-1] = sum ^ CHK_INV;
        if (corrupt)
        begin
            pos     = $urandom_range(0, FRAME - 1);
            fr[pos] = fr[pos] ^ 8'(1 << $urandom_range(0, 7));
        end
        else
        begin
            for (int i = 0; i < FRAME; i++)
                last_frame[slot][i] = fr[i];
        end
        for (int i = 0; i < FRAME; i++)
        begin
            if (i == FRAME / 2)
                repeat (n_ticks) send_item(OP_TICK, 8'($urandom));
            send_item(OP_BYTE, fr[i]);
        end
        frames_sent++;
    endtask

    task automatic drain_reports();
        in_ch.valid <= 1'b0;
        while (pending_report.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_idle_timeout(input logic [CFG_W-1:0] value);
        drain_reports();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en    <= 1'b0;
        timeout_secs = value;
    endtask

    // extremes of the payload, unchanged records, ticks carrying 00 and ff
    task automatic test_record_updates();
        send_item(OP_TICK, 8'hFF);
        send_item(OP_TICK, 8'h00);
        send_frame(HDR_A, PAY_ZERO, 1'b0, 0);
        send_frame(HDR_B, PAY_ONES, 1'b0, 0);
        send_frame(HDR_A, PAY_REPEAT, 1'b0, 0);
        send_frame(HDR_B, PAY_REPEAT, 1'b0, 0);
        send_frame(HDR_A, PAY_RANDOM, 1'b0, 0);
        send_frame(HDR_B, PAY_REPEAT, 1'b0, 0);
    endtask

    // junk ahead of a frame, a broken frame, header without the length byte
    task automatic test_resync();
        send_item(OP_BYTE, HDR_B);
        send_item(OP_BYTE, HDR_LEN);
        send_item(OP_BYTE, 8'h00);
        send_frame(HDR_A, PAY_RANDOM, 1'b0, 0);
        send_frame(HDR_B, PAY_RANDOM, 1'b1, 0);
        send_item(OP_BYTE, HDR_A);
        send_item(OP_BYTE, HDR_A);
        send_frame(HDR_B, PAY_RANDOM, 1'b0, 0);
    endtask

    // partial frames around the idle timeout, zero timeout, long tick run
    // under the largest timeout
    task automatic test_idle_flush();
        set_idle_timeout(8'd1);
        send_frame(HDR_A, PAY_RANDOM, 1'b0, 1);
        send_frame(HDR_B, PAY_RANDOM, 1'b0, 2);
        send_frame(HDR_B, PAY_RANDOM, 1'b0, 0);
        set_idle_timeout(8'd0);
        send_frame(HDR_A, PAY_RANDOM, 1'b0, 1);
        send_frame(HDR_A, PAY_RANDOM, 1'b0, 0);
        set_idle_timeout(8'd255);
        send_frame(HDR_B, PAY_RANDOM, 1'b0, LONG_TICKS);
        set_idle_timeout(TIMEOUT_RST);
    endtask

    // receiver holds off while reports pile up behind new frames
    task automatic test_back_pressure();
        hold_trigger++;
        send_frame(HDR_A, PAY_RANDOM, 1'b0, 0);
        send_frame(HDR_B, PAY_RANDOM, 1'b0, 0);
        send_frame(HDR_A, PAY_RANDOM, 1'b0, 0);
        send_frame(HDR_B, PAY_RANDOM, 1'b0, 0);
        send_frame(HDR_A, PAY_RANDOM, 1'b0, 0);
        drain_reports();
    endtask

    task automatic test_random_stream(input logic [CFG_W-1:0] timeout, input bit no_gaps);
        int unsigned       start;
        int unsigned       pick;
        logic [BYTE_W-1:0] hdr;
        logic [BYTE_W-1:0] noise;
        set_idle_timeout(timeout);
        steady = no_gaps;
        start  = items_sent;
        while (items_sent - start < PHASE_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            hdr  = $urandom_range(0, 1) ? HDR_B : HDR_A;
            if (pick < 60)
                send_frame(hdr, ($urandom_range(0, 99) < 25) ? PAY_REPEAT : PAY_RANDOM, 1'b0,
                           ($urandom_range(0, 99) < 10) ? $urandom_range(1, 3) : 0);
            else if (pick < 70)
                send_frame(hdr, PAY_RANDOM, 1'b1, 0);
            else if (pick < 85)
            begin
                repeat ($urandom_range(1, 4))
                begin
                    case ($urandom_range(0, 5))
                        0:       noise = HDR_A;
                        1:       noise = HDR_B;
                        2:       noise = HDR_LEN;
                        default: noise = 8'($urandom);
                    endcase
                    send_item(OP_BYTE, noise);
                end
            end
            else
                repeat ($urandom_range(1, 4)) send_item(OP_TICK, 8'($urandom));
        end
        steady = 1'b0;
    endtask

    // receiver side: random stalls, plus a long hold when the test asks for one
    initial
    begin : report_sink
        int unsigned hold_seen;
        int unsigned hold_left;
        hold_seen = 0;
        hold_left = 0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_trigger != hold_seen)
            begin
                hold_seen = hold_trigger;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else if (!steady && $urandom_range(0, 99) < IDLE_PCT)
                out_ch.ready <= 1'b0;
            else
                out_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : check_report
        report_byte_t want;
        if (out_ch.valid && out_ch.ready)
        begin
            bytes_checked++;
            if (pending_report.size() == 0)
            begin
                $error("unexpected report byte %02h (last %0b)", out_ch.out_byte, out_ch.out_last);
                errors++;
            end
            else
            begin
                want = pending_report.pop_front();
                if (out_ch.out_byte !== want.data)
                begin
                    $error("out_byte: expected %02h, got %02h", want.data, out_ch.out_byte);
                    errors++;
                end
                if (out_ch.out_last !== want.last)
                begin
                    $error("out_last: expected %0b, got %0b", want.last, out_ch.out_last);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $error("no transaction for %0d cycles, %0d report bytes outstanding",
                   stall_cycles, pending_report.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin
        rst_n           <= 1'b0;
        cfg_wr_en       <= 1'b0;
        cfg_wr_data     <= '0;
        in_ch.valid     <= 1'b0;
        in_ch.operation <= OP_BYTE;
        in_ch.in_byte   <= '0;
        for (int i = 0; i < FRAME; i++)
        begin
            win_bytes[i]     = '0;
            last_frame[0][i] = '0;
            last_frame[1][i] = '0;
        end
        for (int i = 0; i < 2*FRAME; i++)
            rec_bytes[i] = '0;
        win_fill      = 0;
        seen_mask     = MARK_NONE;
        changed_mask  = MARK_NONE;
        idle_secs     = '0;
        timeout_secs  = TIMEOUT_RST;
        items_sent    = 0;
        ticks_sent    = 0;
        frames_sent   = 0;
        reports_due   = 0;
        bytes_checked = 0;
        errors        = 0;
        stall_cycles  = 0;
        hold_trigger  = 0;
        steady        = 1'b0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_record_updates();
        test_resync();
        test_idle_flush();
        test_back_pressure();
        test_random_stream(TIMEOUT_RST, 1'b0);
        test_random_stream(8'd1, 1'b0);
        test_random_stream(8'd0, 1'b1);
        test_random_stream(8'd255, 1'b0);
        test_random_stream(8'd7, 1'b0);

        drain_reports();
        if (pending_report.size() != 0)
        begin
            $error("%0d report bytes never arrived", pending_report.size());
            errors++;
        end
        $display("covered %0d input transactions (%0d frames sent, %0d ticks) over five timeouts",
                 items_sent, frames_sent, ticks_sent);
        $display("%0d reports predicted, %0d report bytes checked, %0d mismatches",
                 reports_due, bytes_checked, errors);
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ----- dual_record_frame_sync_top.f -----
src/drfs_pkg.sv
src/drfs_if.sv
src/drfs_report_buf.sv
src/dual_record_frame_sync_top.sv
src/drfs_checker.sv
test/testbench.sv
